/* rtl/srs_pkg.sv */
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants of the streaming find-and-replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 64;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_NEEDLE_TEXT = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_NEEDLE_LEN  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_REPL_TEXT   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_REPL_LEN    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_REPL_LIMIT  = 3'd4;

  // Limit and count value that means unlimited / saturated
  localparam logic [31:0] UNLIMITED = 32'hFFFF_FFFF;

  // Hard ceiling on needle and replacement lengths
  localparam int LEN_CEIL = 8;

  // Control of one window cell for the current beat
  typedef struct packed {
    logic en;      // input beat accepted
    logic load;    // this cell takes the incoming character
    logic shift;   // take the neighbor's character (oldest one leaves)
    logic in_use;  // cell lies inside the needle length
  } cell_ctl_t;

  // Tail of a result burst: end marker and its count
  typedef struct packed {
    logic        mark;
    logic [31:0] count;
  } burst_tail_t;

endpackage

`default_nettype wire

/* rtl/srs_win_cell.sv */
// ----------------------------------------------------------------------------
// srs_win_cell
// One character of the pending window: load, hold or shift, and compare
// against its needle byte.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_win_cell
  import srs_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic [7:0] in_char,
  input  wire logic [7:0] needle_byte,
  input  wire logic [7:0] right_view,
  output logic [7:0]      view,
  output logic            eq
);

  logic [7:0] held;

  // Window content after the incoming character is placed
  assign view = ctl.load ? in_char : held;
  assign eq   = !ctl.in_use || (view == needle_byte);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      held <= ctl.shift ? right_view : view;
    end
  end

endmodule

`default_nettype wire

/* rtl/srs_emit.sv */
// ----------------------------------------------------------------------------
// srs_emit
// Burst register that holds the results of one input beat and drains them,
// one beat a cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_emit
  import srs_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic [7:0]  ld_chars [DEPTH],
  input  wire logic [3:0]  ld_n,
  input  wire burst_tail_t ld_tail,
  output logic             can_load,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [7:0]       out_char,
  output logic             out_valid,
  output logic             out_last,
  output logic [31:0]      replaced_count
);

  localparam int NW = $clog2(DEPTH + 1);

  logic [7:0]  chars [DEPTH];
  logic [NW-1:0] nchar;
  logic        mark;
  logic [31:0] count;

  logic have;
  logic move;
  logic take;
  logic one_left;

  assign have     = (nchar != '0) || mark;
  assign move     = !res_valid || !res_stall;
  assign take     = move && have;
  assign one_left = (nchar == NW'(1) && !mark) || (nchar == '0 && mark);
  assign can_load = !have || (take && one_left);

  always_ff @(posedge clk) begin
    if (rst) begin
      nchar <= '0;
      mark  <= 1'b0;
    end else if (load) begin
      nchar <= NW'(ld_n);
      mark  <= ld_tail.mark;
    end else if (take) begin
      if (nchar != '0) begin
        nchar <= nchar - NW'(1);
      end else begin
        mark <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars <= ld_chars;
      count <= ld_tail.count;
    end else if (take && nchar != '0) begin
      // advance the burst toward slot zero
      for (int k = 0; k < DEPTH - 1; k++) begin
        chars[k] <= chars[k+1];
      end
      chars[DEPTH-1] <= 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (move) begin
      res_valid <= have;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (nchar != '0) begin
        out_char       <= chars[0];
        out_valid      <= 1'b1;
        out_last       <= 1'b0;
        replaced_count <= '0;
      end else begin
        out_char       <= 8'h00;
        out_valid      <= 1'b0;
        out_last       <= 1'b1;
        replaced_count <= count;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/substring_replace_stream_unit.sv */
// ----------------------------------------------------------------------------
// substring_replace_stream_unit
// Streaming find-and-replace: a row of window cells compares the pending
// characters with the needle, and a burst register drains the results.
// ----------------------------------------------------------------------------
// Path: the results of a beat enter the burst register when the beat is
//   accepted and pass from there to the output register.
// Throughput: one input beat per cycle while each beat causes at most one
//   result and the output is not stalled; a beat causing k results holds
//   the input while the burst register drains one result a cycle (k is 0 to 9).
// Reset: synchronous; clears window fill, string state, counters and
//   configuration registers to their defaults. No clearing pass.
`default_nettype none

module substring_replace_stream_unit
  import srs_pkg::*;
#(
  parameter int MAX_NEEDLE      = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_char,
  input  wire logic              in_last,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output logic [7:0]             out_char,
  output logic                   out_valid,
  output logic                   out_last,
  output logic [31:0]            replaced_count,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  localparam int WIN  = (MAX_NEEDLE < LEN_CEIL) ? MAX_NEEDLE : LEN_CEIL;
  localparam int RCAP = (MAX_REPLACEMENT < LEN_CEIL) ? MAX_REPLACEMENT : LEN_CEIL;
  localparam int BW   = (WIN > RCAP) ? WIN : RCAP;
  localparam logic [3:0] WIN_L  = 4'(WIN);
  localparam logic [3:0] RCAP_L = 4'(RCAP);

  // Configuration registers
  logic [63:0] needle_text;
  logic [3:0]  needle_length;
  logic [63:0] replacement_text;
  logic [3:0]  replacement_length;
  logic [31:0] replacement_limit;

  // String state
  logic        active;
  logic [3:0]  latched_len;
  logic [3:0]  fill;
  logic [31:0] left;
  logic [31:0] done;

  logic        acc;
  logic        can_load;
  logic [3:0]  len_start;
  logic [3:0]  len;
  logic [3:0]  win;
  logic [3:0]  fill0;
  logic [31:0] left0;
  logic [31:0] done0;
  logic        append;
  logic [3:0]  f1;
  logic        full;
  logic        match;
  logic [3:0]  rl;
  logic [31:0] done_next;
  logic [31:0] left_next;
  logic [3:0]  fill_next;
  logic [3:0]  ld_n;
  burst_tail_t ld_tail;

  logic [7:0]     view [WIN];
  logic [WIN-1:0] eq_vec;
  logic [7:0]     ld_chars [BW];

  assign cfg_ready = 1'b1;
  assign acc       = in_valid && !in_stall;
  assign in_stall  = !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_text        <= '0;
      needle_length      <= 4'd1;
      replacement_text   <= '0;
      replacement_length <= '0;
      replacement_limit  <= UNLIMITED;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NEEDLE_TEXT: needle_text        <= cfg_data;
        CFG_NEEDLE_LEN:  needle_length      <= cfg_data[3:0];
        CFG_REPL_TEXT:   replacement_text   <= cfg_data;
        CFG_REPL_LEN:    replacement_length <= cfg_data[3:0];
        CFG_REPL_LIMIT:  replacement_limit  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Start-of-string values stand in for the held state on the first beat
  assign len_start = (needle_length > WIN_L) ? WIN_L : needle_length;
  assign len       = active ? latched_len : len_start;
  assign win       = (len == 4'd0) ? 4'd1 : len;
  assign fill0     = active ? fill : 4'd0;
  assign left0     = active ? left : replacement_limit;
  assign done0     = active ? done : 32'd0;

  assign append = fill0 < win;
  assign f1     = append ? fill0 + 4'd1 : fill0;
  assign full   = f1 >= win;
  assign match  = full && (len != 4'd0) && (left0 != 32'd0) && (&eq_vec);
  assign rl     = (replacement_length > RCAP_L) ? RCAP_L : replacement_length;

  assign done_next = (match && done0 != UNLIMITED) ? done0 + 32'd1 : done0;
  assign left_next = (match && left0 != UNLIMITED) ? left0 - 32'd1 : left0;

  always_comb begin
    if (match) begin
      fill_next = 4'd0;
    end else if (full) begin
      fill_next = f1 - 4'd1;
    end else begin
      fill_next = f1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      latched_len <= '0;
      fill        <= '0;
      left        <= UNLIMITED;
      done        <= '0;
    end else if (acc) begin
      active      <= !in_last;
      latched_len <= len;
      fill        <= in_last ? 4'd0 : fill_next;
      left        <= left_next;
      done        <= done_next;
    end
  end

  // Row of window cells
  for (genvar i = 0; i < WIN; i++) begin : g_cell
    cell_ctl_t  ctl;
    logic [7:0] right_view;

    assign ctl.en     = acc;
    assign ctl.load   = append && (fill0 == 4'(i));
    assign ctl.shift  = full && !match;
    assign ctl.in_use = 4'(i) < win;

    if (i < WIN - 1) begin : g_mid
      assign right_view = view[i+1];
    end else begin : g_end
      assign right_view = 8'h00;
    end

    srs_win_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .in_char     (in_char),
      .needle_byte (needle_text[8*i +: 8]),
      .right_view  (right_view),
      .view        (view[i]),
      .eq          (eq_vec[i])
    );
  end

  // Burst content: the replacement, or a prefix of the window
  for (genvar j = 0; j < BW; j++) begin : g_burst
    logic [7:0] rbyte;
    logic [7:0] wbyte;

    if (j < RCAP) begin : g_r
      assign rbyte = replacement_text[8*j +: 8];
    end else begin : g_rz
      assign rbyte = 8'h00;
    end

    if (j < WIN) begin : g_w
      assign wbyte = view[j];
    end else begin : g_wz
      assign wbyte = 8'h00;
    end

    assign ld_chars[j] = match ? rbyte : wbyte;
  end

  always_comb begin
    if (match) begin
      ld_n = rl;
    end else if (in_last) begin
      ld_n = f1;
    end else if (full) begin
      ld_n = 4'd1;
    end else begin
      ld_n = 4'd0;
    end
  end

  assign ld_tail.mark  = in_last;
  assign ld_tail.count = done_next;

  srs_emit #(
    .DEPTH (BW)
  ) u_emit (
    .clk            (clk),
    .rst            (rst),
    .load           (acc),
    .ld_chars       (ld_chars),
    .ld_n           (ld_n),
    .ld_tail        (ld_tail),
    .can_load       (can_load),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .out_char       (out_char),
    .out_valid      (out_valid),
    .out_last       (out_last),
    .replaced_count (replaced_count)
  );

endmodule

`default_nettype wire
